[rtl/sfo_pkg.sv]
// Shared types, codes and tables for the six-frame longest ORF unit.
// Used by the codon unit, the run tracker, the top level and the checker.
// No dependencies.
package sfo_pkg;

  // Action codes of an input transaction
  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_FINISH = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;
  localparam logic [1:0] ACT_NONE   = 2'd3;

  // Status codes of a result transaction
  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_FULL  = 2'd1;
  localparam logic [1:0] STS_RANGE = 2'd2;

  // ASCII residue letters
  localparam logic [7:0] CH_M    = 8'h4D;
  localparam logic [7:0] CH_STOP = 8'h2A;
  localparam logic [7:0] CH_X    = 8'h58;

  // Standard codon table, index {b0, b1, b2} with a=0 c=1 g=2 t=3
  localparam logic [7:0] AA_TABLE [64] = '{
    "K", "N", "K", "N", "T", "T", "T", "T", "R", "S", "R", "S", "I", "I", "M", "I",
    "Q", "H", "Q", "H", "P", "P", "P", "P", "R", "R", "R", "R", "L", "L", "L", "L",
    "E", "D", "E", "D", "A", "A", "A", "A", "G", "G", "G", "G", "V", "V", "V", "V",
    "*", "Y", "*", "Y", "S", "S", "S", "S", "*", "C", "W", "C", "L", "F", "L", "F"
  };

  // Control from the sequencer to the run tracker
  typedef struct packed {
    logic       clear;   // start of a new search
    logic       step;    // one residue (or end of frame) to process
    logic       at_end;  // past the last whole codon of the frame
    logic       strand;
    logic [1:0] frame;
  } trk_ctl_t;

  // Stored base code: [3] has complement, [2] lowercase acgt, [1:0] base
  function automatic logic [3:0] encode_base(input logic [7:0] c);
    logic [3:0] e;
    case (c)
      8'h61:   e = 4'b1100; // a
      8'h63:   e = 4'b1101; // c
      8'h67:   e = 4'b1110; // g
      8'h74:   e = 4'b1111; // t
      8'h41:   e = 4'b1000; // A
      8'h43:   e = 4'b1001; // C
      8'h47:   e = 4'b1010; // G
      8'h54:   e = 4'b1011; // T
      8'h75:   e = 4'b1011; // u
      default: e = 4'b0000;
    endcase
    return e;
  endfunction

endpackage

[rtl/sfo_codon_unit.sv]
// Base store and codon fetch: holds the loaded bases in a memory with one
// write port and one read port, and turns three successive reads on either
// strand into one residue letter. Depends on sfo_pkg.
module sfo_codon_unit #(
  parameter int MAX_BASES = 4096,
  localparam int AW = $clog2(MAX_BASES),
  localparam int CW = $clog2(MAX_BASES + 1),
  localparam int PW = CW + 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [3:0]    wr_data,
  input  logic [CW-1:0] base_cnt,
  input  logic          req_start,
  input  logic          req_strand,
  input  logic [PW-1:0] req_pos,
  output logic          done,
  output logic [7:0]    res
);

  logic [3:0]    mem [MAX_BASES];

  logic          act_r, act_nxt;
  logic [1:0]    k_r, k_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic          rd_last_r, rd_last_nxt;
  logic          done_r, done_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic          dir_r, dir_nxt;
  logic [5:0]    codon_r, codon_nxt;
  logic          unk_r, unk_nxt;
  logic [7:0]    res_r, res_nxt;
  logic [3:0]    rdata_r;

  logic          in_range;
  logic [PW:0]   rev_pos;
  logic [1:0]    base;
  logic          base_ok;

  assign in_range = (PW+1)'(req_pos) + (PW+1)'(3) <= (PW+1)'(base_cnt);
  assign rev_pos  = (PW+1)'(base_cnt) - (PW+1)'(req_pos) - (PW+1)'(1);

  // Reverse strand reads the complement: 3 - b is ~b on two bits
  assign base    = dir_r ? ~rdata_r[1:0] : rdata_r[1:0];
  assign base_ok = dir_r ? rdata_r[3] : rdata_r[2];

  always_comb begin
    act_nxt     = act_r;
    k_nxt       = k_r;
    rd_vld_nxt  = 1'b0;
    rd_last_nxt = 1'b0;
    done_nxt    = 1'b0;
    addr_nxt    = addr_r;
    dir_nxt     = dir_r;
    codon_nxt   = codon_r;
    unk_nxt     = unk_r;
    res_nxt     = res_r;
    if (req_start) begin
      if (in_range) begin
        act_nxt  = 1'b1;
        k_nxt    = 2'd0;
        addr_nxt = req_strand ? rev_pos[AW-1:0] : req_pos[AW-1:0];
        dir_nxt  = req_strand;
        unk_nxt  = 1'b0;
      end else begin
        // codon would run past the end of the store
        done_nxt = 1'b1;
        res_nxt  = sfo_pkg::CH_X;
      end
    end
    if (act_r) begin
      rd_vld_nxt  = 1'b1;
      rd_last_nxt = (k_r == 2'd2);
      addr_nxt    = dir_r ? addr_r - AW'(1) : addr_r + AW'(1);
      k_nxt       = k_r + 2'd1;
      if (k_r == 2'd2) begin
        act_nxt = 1'b0;
      end
    end
    if (rd_vld_r) begin
      codon_nxt = {codon_r[3:0], base};
      unk_nxt   = unk_r | ~base_ok;
      if (rd_last_r) begin
        done_nxt = 1'b1;
        res_nxt  = unk_nxt ? sfo_pkg::CH_X : sfo_pkg::AA_TABLE[codon_nxt];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r     <= 1'b0;
      k_r       <= 2'd0;
      rd_vld_r  <= 1'b0;
      rd_last_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      act_r     <= act_nxt;
      k_r       <= k_nxt;
      rd_vld_r  <= rd_vld_nxt;
      rd_last_r <= rd_last_nxt;
      done_r    <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r  <= addr_nxt;
    dir_r   <= dir_nxt;
    codon_r <= codon_nxt;
    unk_r   <= unk_nxt;
    res_r   <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (act_r) begin
      rdata_r <= mem[addr_r];
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

[rtl/sfo_run_tracker.sv]
// Open-run tracking and best-run registers for the ORF search.
// Takes one residue per step from the sequencer. Depends on sfo_pkg.
module sfo_run_tracker #(
  parameter int MAX_BASES = 4096,
  localparam int CW = $clog2(MAX_BASES + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sfo_pkg::trk_ctl_t ctl,
  input  logic [7:0]        res,
  input  logic [CW-1:0]     idx,
  output logic              best_strand,
  output logic [1:0]        best_frame,
  output logic [CW-1:0]     best_off,
  output logic [CW-1:0]     best_len
);

  logic          open_r, open_nxt;
  logic [CW-1:0] start_r, start_nxt;
  logic          bstr_r, bstr_nxt;
  logic [1:0]    bfrm_r, bfrm_nxt;
  logic [CW-1:0] boff_r, boff_nxt;
  logic [CW-1:0] blen_r, blen_nxt;

  logic          can_open;
  logic          open_eff;
  logic [CW-1:0] start_eff;
  logic [CW-1:0] run_len;

  // A run opens at residue 0 or at an M
  assign can_open  = ~open_r & ~ctl.at_end & ((idx == '0) | (res == sfo_pkg::CH_M));
  assign open_eff  = open_r | can_open;
  assign start_eff = can_open ? idx : start_r;
  assign run_len   = idx - start_eff;

  always_comb begin
    open_nxt  = open_r;
    start_nxt = start_r;
    bstr_nxt  = bstr_r;
    bfrm_nxt  = bfrm_r;
    boff_nxt  = boff_r;
    blen_nxt  = blen_r;
    if (ctl.clear) begin
      open_nxt = 1'b0;
      bstr_nxt = 1'b0;
      bfrm_nxt = 2'd0;
      boff_nxt = '0;
      blen_nxt = '0;
    end else if (ctl.step) begin
      if (ctl.at_end || res == sfo_pkg::CH_STOP) begin
        // strictly longer only: ties keep the earlier run
        if (open_eff && run_len > blen_r) begin
          bstr_nxt = ctl.strand;
          bfrm_nxt = ctl.frame;
          boff_nxt = start_eff;
          blen_nxt = run_len;
        end
        open_nxt = 1'b0;
      end else begin
        open_nxt  = open_eff;
        start_nxt = start_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r  <= 1'b0;
      start_r <= '0;
      bstr_r  <= 1'b0;
      bfrm_r  <= 2'd0;
      boff_r  <= '0;
      blen_r  <= '0;
    end else begin
      open_r  <= open_nxt;
      start_r <= start_nxt;
      bstr_r  <= bstr_nxt;
      bfrm_r  <= bfrm_nxt;
      boff_r  <= boff_nxt;
      blen_r  <= blen_nxt;
    end
  end

  assign best_strand = bstr_r;
  assign best_frame  = bfrm_r;
  assign best_off    = boff_r;
  assign best_len    = blen_r;

endmodule

[rtl/six_frame_longest_orf_unit.sv]
// Six-frame longest ORF unit. A load transaction stores one base, or gives
// STS_FULL once the store is full, and is answered on the next cycle; busy
// stays low, so loads stream one per cycle. A finish transaction walks forward
// frames 0..2 then reverse frames 0..2, one codon at a time through the base
// memory (three reads per codon, then a closing step for each frame), and is
// answered after the last frame is closed. A read transaction that is in range
// fetches its codon from the base memory before it is answered; an
// out-of-range read or an ignored action is answered on the next cycle.
// Every transaction gives exactly one result, shown for one cycle
// on out_strobe; the receiver cannot stall, so take it then. Best-run fields
// always show the current best registers.
// Depends on sfo_pkg, sfo_codon_unit and sfo_run_tracker.
module six_frame_longest_orf_unit #(
  parameter int MAX_BASES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_base_char,
  input  logic [10:0] in_residue_index,
  output logic        out_strobe,
  output logic [1:0]  out_status,
  output logic        out_best_strand,
  output logic [1:0]  out_best_frame,
  output logic [10:0] out_protein_offset,
  output logic [10:0] out_protein_length,
  output logic [11:0] out_dna_start,
  output logic [7:0]  out_residue
);

  localparam int AW = $clog2(MAX_BASES);
  localparam int CW = $clog2(MAX_BASES + 1);
  localparam int PW = CW + 1;
  localparam int IW = (CW > 11) ? CW : 11;
  localparam int XW = (CW > 12) ? CW : 12;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_STEP   = 3'd1;
  localparam logic [2:0] ST_WAIT   = 3'd2;
  localparam logic [2:0] ST_RSTART = 3'd3;
  localparam logic [2:0] ST_READ   = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          sstr_r, sstr_nxt;
  logic [1:0]    sfrm_r, sfrm_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          strobe_r, strobe_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [7:0]    residue_r, residue_nxt;

  logic              accept;
  logic              full;
  logic              wr_en;
  logic              frm_more;
  logic              req_start;
  logic              req_strand;
  logic              cod_done;
  logic [7:0]        cod_res;
  sfo_pkg::trk_ctl_t trk_ctl;
  logic [7:0]        trk_res;
  logic              best_strand;
  logic [1:0]        best_frame;
  logic [CW-1:0]     best_off;
  logic [CW-1:0]     best_len;
  logic              rd_err;
  logic [PW:0]       rd_sum;
  logic [PW:0]       rd_pos;
  logic [XW-1:0]     off_x;
  logic [XW-1:0]     len_x;
  logic [XW+1:0]     dna_x;

  assign accept   = start & ~busy;
  assign full     = (cnt_r == CW'(MAX_BASES));
  assign wr_en    = accept & (in_action == sfo_pkg::ACT_LOAD) & ~full;
  assign frm_more = (PW+1)'(pos_r) + (PW+1)'(3) <= (PW+1)'(cnt_r);

  assign rd_err = IW'(in_residue_index) >= IW'(best_len);
  assign rd_sum = (PW+1)'(best_off) + (PW+1)'(in_residue_index);
  assign rd_pos = (rd_sum << 1) + rd_sum + (PW+1)'(best_frame);

  assign req_start  = ((state_r == ST_STEP) & frm_more) | (state_r == ST_RSTART);
  assign req_strand = (state_r == ST_RSTART) ? best_strand : sstr_r;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    sstr_nxt    = sstr_r;
    sfrm_nxt    = sfrm_r;
    pos_nxt     = pos_r;
    idx_nxt     = idx_r;
    strobe_nxt  = 1'b0;
    status_nxt  = status_r;
    residue_nxt = residue_r;
    trk_ctl     = '{clear: 1'b0, step: 1'b0, at_end: 1'b0, strand: sstr_r, frame: sfrm_r};
    trk_res     = cod_res;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          status_nxt  = sfo_pkg::STS_OK;
          residue_nxt = 8'd0;
          case (in_action)
            sfo_pkg::ACT_LOAD: begin
              strobe_nxt = 1'b1;
              if (full) begin
                status_nxt = sfo_pkg::STS_FULL;
              end else begin
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            sfo_pkg::ACT_FINISH: begin
              trk_ctl.clear = 1'b1;
              sstr_nxt      = 1'b0;
              sfrm_nxt      = 2'd0;
              pos_nxt       = '0;
              idx_nxt       = '0;
              state_nxt     = ST_STEP;
            end
            sfo_pkg::ACT_READ: begin
              if (rd_err) begin
                strobe_nxt = 1'b1;
                status_nxt = sfo_pkg::STS_RANGE;
              end else begin
                pos_nxt   = rd_pos[PW-1:0];
                state_nxt = ST_RSTART;
              end
            end
            default: begin
              strobe_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_STEP: begin
        if (frm_more) begin
          state_nxt = ST_WAIT;
        end else begin
          // close the frame as if a stop followed the last codon
          trk_ctl.step   = 1'b1;
          trk_ctl.at_end = 1'b1;
          trk_res        = sfo_pkg::CH_STOP;
          idx_nxt        = '0;
          if (sfrm_r == 2'd2) begin
            sfrm_nxt = 2'd0;
            pos_nxt  = '0;
            if (sstr_r) begin
              strobe_nxt = 1'b1;
              state_nxt  = ST_IDLE;
            end else begin
              sstr_nxt = 1'b1;
            end
          end else begin
            sfrm_nxt = sfrm_r + 2'd1;
            pos_nxt  = PW'(sfrm_r + 2'd1);
          end
        end
      end
      ST_WAIT: begin
        if (cod_done) begin
          trk_ctl.step = 1'b1;
          idx_nxt      = idx_r + CW'(1);
          pos_nxt      = pos_r + PW'(3);
          state_nxt    = ST_STEP;
        end
      end
      ST_RSTART: begin
        state_nxt = ST_READ;
      end
      ST_READ: begin
        if (cod_done) begin
          residue_nxt = cod_res;
          strobe_nxt  = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sstr_r    <= sstr_nxt;
    sfrm_r    <= sfrm_nxt;
    pos_r     <= pos_nxt;
    idx_r     <= idx_nxt;
    status_r  <= status_nxt;
    residue_r <= residue_nxt;
  end

  sfo_codon_unit #(
    .MAX_BASES(MAX_BASES)
  ) u_codon (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_en),
    .wr_addr   (cnt_r[AW-1:0]),
    .wr_data   (sfo_pkg::encode_base(in_base_char)),
    .base_cnt  (cnt_r),
    .req_start (req_start),
    .req_strand(req_strand),
    .req_pos   (pos_r),
    .done      (cod_done),
    .res       (cod_res)
  );

  sfo_run_tracker #(
    .MAX_BASES(MAX_BASES)
  ) u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (trk_ctl),
    .res        (trk_res),
    .idx        (idx_r),
    .best_strand(best_strand),
    .best_frame (best_frame),
    .best_off   (best_off),
    .best_len   (best_len)
  );

  assign off_x = XW'(best_off);
  assign len_x = XW'(best_len);
  assign dna_x = (XW+2)'({off_x, 1'b0}) + (XW+2)'(off_x) + (XW+2)'(best_frame);

  assign busy               = (state_r != ST_IDLE);
  assign out_strobe         = strobe_r;
  assign out_status         = status_r;
  assign out_residue        = residue_r;
  assign out_best_strand    = best_strand;
  assign out_best_frame     = best_frame;
  assign out_protein_offset = off_x[10:0];
  assign out_protein_length = len_x[10:0];
  assign out_dna_start      = dna_x[11:0];

endmodule

[rtl/sfo_checker.sv]
// Port-level checks for the six-frame longest ORF unit, bound to the top level.
// Depends on sfo_pkg.
module sfo_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_action,
  input  logic        out_strobe,
  input  logic [1:0]  out_status,
  input  logic        out_best_strand,
  input  logic [1:0]  out_best_frame,
  input  logic [10:0] out_protein_offset,
  input  logic [10:0] out_protein_length,
  input  logic [7:0]  out_residue
);

  // a load transaction is answered on the next cycle
  a_load_answer: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_action == sfo_pkg::ACT_LOAD |=> out_strobe)
    else $error("load transaction not answered on next cycle");

  // a result never appears while the unit is still working
  a_no_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_strobe)
    else $error("result strobe while busy");

  // busy only rises after an accepted transaction
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a start");

  // any non-ok result carries no residue
  a_err_residue: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status != sfo_pkg::STS_OK |-> out_residue == 8'd0)
    else $error("residue reported on an error result");

  // no run found leaves every best field at zero
  a_empty_best: assert property (@(posedge clk) disable iff (!rst_n)
    out_protein_length == 11'd0 |->
      out_protein_offset == 11'd0 && out_best_strand == 1'b0 && out_best_frame == 2'd0)
    else $error("best fields set with zero length");

endmodule

bind six_frame_longest_orf_unit sfo_checker u_sfo_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_action         (in_action),
  .out_strobe        (out_strobe),
  .out_status        (out_status),
  .out_best_strand   (out_best_strand),
  .out_best_frame    (out_best_frame),
  .out_protein_offset(out_protein_offset),
  .out_protein_length(out_protein_length),
  .out_residue       (out_residue)
);
